// ===== rtl/json_string_unescape_defines.svh =====
// assertion helpers shared by the rtl
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// checked only outside reset
`define JSU_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define JSU_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

   localparam logic [1:0] STATUS_DATA = 2'd0;
   localparam logic [1:0] STATUS_END  = 2'd1;
   localparam logic [1:0] STATUS_ERR  = 2'd2;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_SLASH     = 8'h2f;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6e;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_EOF       = 8'hff;

   localparam logic [7:0] BYTE_BS = 8'h08;
   localparam logic [7:0] BYTE_FF = 8'h0c;
   localparam logic [7:0] BYTE_LF = 8'h0a;
   localparam logic [7:0] BYTE_CR = 8'h0d;
   localparam logic [7:0] BYTE_HT = 8'h09;

   localparam logic [2:0] HEX_IDLE  = 3'd0;
   localparam logic [2:0] HEX_START = 3'd1;
   localparam logic [2:0] HEX_FINAL = 3'd4;

   localparam logic [4:0] HEX_BAD = 5'd16;

   // one queued record: up to three result beats
   typedef struct packed {
      logic [1:0]      cnt;
      logic [2:0][7:0] bytes;
      logic [1:0]      status;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] d;
      d = HEX_BAD;
      if (c inside {[8'h30:8'h39]}) begin
         d = {1'b0, c[3:0]};
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         d = {1'b0, c[3:0] + 4'd9};
      end
      return d;
   endfunction

   function automatic rec_type single(input logic [7:0] b, input logic [1:0] st);
      rec_type r;
      r.cnt    = 2'd1;
      r.bytes  = '0;
      r.bytes[0] = b;
      r.status = st;
      return r;
   endfunction

   function automatic rec_type utf8(input logic [15:0] v);
      rec_type r;
      r.status = STATUS_DATA;
      r.bytes  = '0;
      if (v[15:7] == '0) begin
         r.cnt      = 2'd1;
         r.bytes[0] = {1'b0, v[6:0]};
      end else if (v[15:11] == '0) begin
         r.cnt      = 2'd2;
         r.bytes[0] = {3'b110, v[10:6]};
         r.bytes[1] = {2'b10, v[5:0]};
      end else begin
         r.cnt      = 2'd3;
         r.bytes[0] = {4'b1110, v[15:12]};
         r.bytes[1] = {2'b10, v[11:6]};
         r.bytes[2] = {2'b10, v[5:0]};
      end
      return r;
   endfunction

endpackage

// ===== rtl/jsu_front.sv =====
`timescale 1ns / 1ps
`include "json_string_unescape_defines.svh"

module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   output logic             push,
   output jsu_pkg::rec_type rec
);

   logic        esc_ff, esc_in;
   logic [2:0]  digits_ff, digits_in;
   logic [15:0] acc_ff, acc_in;
   logic [4:0]  d;
   logic [15:0] acc_next;

   always_comb begin
      d        = jsu_pkg::hex_value(in_byte);
      acc_next = {acc_ff[11:0], d[3:0]};
      esc_in    = esc_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      push      = 1'b0;
      rec       = jsu_pkg::single(8'h00, jsu_pkg::STATUS_ERR);
      if (digits_ff != jsu_pkg::HEX_IDLE) begin
         if (d[4]) begin
            push      = 1'b1;
            digits_in = jsu_pkg::HEX_IDLE;
            acc_in    = '0;
         end else if (digits_ff == jsu_pkg::HEX_FINAL) begin
            push      = 1'b1;
            rec       = jsu_pkg::utf8(acc_next);
            digits_in = jsu_pkg::HEX_IDLE;
            acc_in    = '0;
         end else begin
            digits_in = digits_ff + 3'd1;
            acc_in    = acc_next;
         end
      end else if (esc_ff) begin
         esc_in = 1'b0;
         push   = 1'b1;
         case (in_byte)
            jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_SLASH: begin
               rec = jsu_pkg::single(in_byte, jsu_pkg::STATUS_DATA);
            end
            jsu_pkg::CHAR_B: rec = jsu_pkg::single(jsu_pkg::BYTE_BS, jsu_pkg::STATUS_DATA);
            jsu_pkg::CHAR_F: rec = jsu_pkg::single(jsu_pkg::BYTE_FF, jsu_pkg::STATUS_DATA);
            jsu_pkg::CHAR_N: rec = jsu_pkg::single(jsu_pkg::BYTE_LF, jsu_pkg::STATUS_DATA);
            jsu_pkg::CHAR_R: rec = jsu_pkg::single(jsu_pkg::BYTE_CR, jsu_pkg::STATUS_DATA);
            jsu_pkg::CHAR_T: rec = jsu_pkg::single(jsu_pkg::BYTE_HT, jsu_pkg::STATUS_DATA);
            jsu_pkg::CHAR_U: begin
               push      = 1'b0;
               digits_in = jsu_pkg::HEX_START;
               acc_in    = '0;
            end
            default: rec = jsu_pkg::single(8'h00, jsu_pkg::STATUS_ERR);
         endcase
      end else begin
         push = 1'b1;
         if (in_byte == jsu_pkg::CHAR_EOF || in_byte[7:2] == '0) begin
            rec = jsu_pkg::single(8'h00, jsu_pkg::STATUS_ERR);
         end else if (in_byte == jsu_pkg::CHAR_QUOTE) begin
            rec = jsu_pkg::single(8'h00, jsu_pkg::STATUS_END);
         end else if (in_byte == jsu_pkg::CHAR_BACKSLASH) begin
            push   = 1'b0;
            esc_in = 1'b1;
         end else begin
            rec = jsu_pkg::single(in_byte, jsu_pkg::STATUS_DATA);
         end
      end
      if (!accept) begin
         push      = 1'b0;
         esc_in    = esc_ff;
         digits_in = digits_ff;
         acc_in    = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff    <= 1'b0;
         digits_ff <= jsu_pkg::HEX_IDLE;
         acc_ff    <= '0;
      end else begin
         esc_ff    <= esc_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
      end
   end

   `JSU_ASSERT(a_front_mode, !(esc_ff && digits_ff != jsu_pkg::HEX_IDLE) && digits_ff <= jsu_pkg::HEX_FINAL, "escape and hex mode overlap")

endmodule

// ===== rtl/jsu_queue.sv =====
`timescale 1ns / 1ps
`include "json_string_unescape_defines.svh"

module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enq,
   input  jsu_pkg::rec_type      enq_rec,
   input  logic                  deq,
   output jsu_pkg::rec_type      head_rec,
   output jsu_pkg::q_status_type q_status
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   jsu_pkg::rec_type mem [DEPTH];
   logic [ADDR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_enq, do_deq;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_enq = enq && !q_status.full;
   assign do_deq = deq && !q_status.empty;
   assign head_rec = mem[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_enq) begin
         wr_in = (wr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_deq) begin
         rd_in = (rd_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_enq && !do_deq) begin
         count_in = count_ff + 1'b1;
      end else if (do_deq && !do_enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         mem[wr_ff] <= enq_rec;
      end
   end

   `JSU_ASSERT(a_q_count, (do_enq && !do_deq) |=> (count_ff == $past(count_ff) + 1'b1), "queue count lost an entry")

endmodule

// ===== rtl/jsu_back.sv =====
`timescale 1ns / 1ps
`include "json_string_unescape_defines.svh"

module jsu_back (
   input  logic                  clock,
   input  logic                  reset,
   input  jsu_pkg::q_status_type q_status,
   input  jsu_pkg::rec_type      head_rec,
   output logic                  deq,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [7:0]            rsp_out_byte,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last
);

   jsu_pkg::rec_type cur_ff, cur_in;
   logic [1:0]       idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic             beat, done;

   assign rsp_empty    = !valid_ff;
   assign rsp_last     = (idx_ff == cur_ff.cnt - 2'd1);
   assign rsp_status   = cur_ff.status;
   assign rsp_out_byte = cur_ff.bytes[idx_ff];
   assign beat         = rsp_pop && valid_ff;
   assign done         = !valid_ff || (beat && rsp_last);
   assign deq          = done && !q_status.empty;

   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (deq) begin
         cur_in   = head_rec;
         idx_in   = 2'd0;
         valid_in = 1'b1;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (beat) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      cur_ff <= cur_in;
   end

   `JSU_ASSERT(a_back_idx, valid_ff |-> (idx_ff < cur_ff.cnt), "beat index past record")
   `JSU_ASSERT(a_back_hold, (beat && !rsp_last) |=> (valid_ff && idx_ff == $past(idx_ff) + 2'd1), "record dropped mid-sequence")

endmodule

// ===== rtl/json_string_unescape.sv =====
// records enter the queue as bytes are accepted; the output stage then registers them
// throughput: a byte per cycle unless req_full; a beat per cycle while rsp_pop is high
// a unicode escape turns six bytes into up to three beats, so the input sets the bound
// the record queue between decoder and output stage holds QUEUE_DEPTH entries
// reset (synchronous, active high) clears the escape state and empties the queue
`timescale 1ns / 1ps

module json_string_unescape #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   jsu_pkg::rec_type      front_rec, head_rec;
   jsu_pkg::q_status_type q_status;
   logic                  front_push, deq, accept;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   jsu_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .push    (front_push),
      .rec     (front_rec)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (front_push),
      .enq_rec  (front_rec),
      .deq      (deq),
      .head_rec (head_rec),
      .q_status (q_status)
   );

   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .head_rec     (head_rec),
      .deq          (deq),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== sim/json_string_unescape_checker.sv =====
`timescale 1ns / 1ps

module json_string_unescape_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_pop,
   input  logic       rsp_empty,
   input  logic [7:0] rsp_out_byte,
   input  logic [1:0] rsp_status,
   input  logic       rsp_last,
   output int         failures,
   output int         beats_outstanding
);

   localparam logic [2:0] HEX_COMPLETE = 3'd5;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       last;
   } beat_type;

   beat_type expected_beats[$];

   logic        escape_pending;
   logic [2:0]  hex_digits_seen;
   logic [15:0] hex_accum;

   initial begin
      failures = 0;
      beats_outstanding = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $realtime, what);
      failures++;
   endtask

   task automatic expect_beat(input logic [7:0] b, input logic [1:0] st, input logic last);
      beat_type beat;
      beat.out_byte = b;
      beat.status   = st;
      beat.last     = last;
      expected_beats.push_back(beat);
   endtask

   task automatic clear_escape;
      escape_pending  = 1'b0;
      hex_digits_seen = jsu_pkg::HEX_IDLE;
      hex_accum       = '0;
   endtask

   task automatic expect_signal(input logic [1:0] st);
      clear_escape();
      expect_beat(8'h00, st, 1'b1);
   endtask

   task automatic expect_utf8(input logic [15:0] v);
      if (v < 16'h0080) begin
         expect_beat(v[7:0], jsu_pkg::STATUS_DATA, 1'b1);
      end else if (v < 16'h0800) begin
         expect_beat(8'hc0 | {3'b000, v[10:6]}, jsu_pkg::STATUS_DATA, 1'b0);
         expect_beat(8'h80 | {2'b00, v[5:0]}, jsu_pkg::STATUS_DATA, 1'b1);
      end else begin
         expect_beat(8'he0 | {4'h0, v[15:12]}, jsu_pkg::STATUS_DATA, 1'b0);
         expect_beat(8'h80 | {2'b00, v[11:6]}, jsu_pkg::STATUS_DATA, 1'b0);
         expect_beat(8'h80 | {2'b00, v[5:0]}, jsu_pkg::STATUS_DATA, 1'b1);
      end
   endtask

   task automatic decode_byte(input logic [7:0] c);
      logic [4:0]  nib;
      logic [15:0] code_unit;
      if (hex_digits_seen != jsu_pkg::HEX_IDLE) begin
         // 16 marks a byte that is not a hex digit
         nib = jsu_pkg::hex_value(c);
         if (nib[4]) begin
            expect_signal(jsu_pkg::STATUS_ERR);
         end else begin
            hex_accum = {hex_accum[11:0], nib[3:0]};
            hex_digits_seen = hex_digits_seen + 3'd1;
            if (hex_digits_seen == HEX_COMPLETE) begin
               code_unit = hex_accum;
               clear_escape();
               expect_utf8(code_unit);
            end
         end
      end else if (escape_pending) begin
         escape_pending = 1'b0;
         case (c)
            jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_SLASH: begin
               expect_beat(c, jsu_pkg::STATUS_DATA, 1'b1);
            end
            jsu_pkg::CHAR_B: expect_beat(jsu_pkg::BYTE_BS, jsu_pkg::STATUS_DATA, 1'b1);
            jsu_pkg::CHAR_F: expect_beat(jsu_pkg::BYTE_FF, jsu_pkg::STATUS_DATA, 1'b1);
            jsu_pkg::CHAR_N: expect_beat(jsu_pkg::BYTE_LF, jsu_pkg::STATUS_DATA, 1'b1);
            jsu_pkg::CHAR_R: expect_beat(jsu_pkg::BYTE_CR, jsu_pkg::STATUS_DATA, 1'b1);
            jsu_pkg::CHAR_T: expect_beat(jsu_pkg::BYTE_HT, jsu_pkg::STATUS_DATA, 1'b1);
            jsu_pkg::CHAR_U: begin
               hex_digits_seen = jsu_pkg::HEX_START;
               hex_accum = '0;
            end
            default: expect_signal(jsu_pkg::STATUS_ERR);
         endcase
      end else if (c == jsu_pkg::CHAR_EOF || c[7:2] == 6'd0) begin
         expect_signal(jsu_pkg::STATUS_ERR);
      end else if (c == jsu_pkg::CHAR_QUOTE) begin
         expect_signal(jsu_pkg::STATUS_END);
      end else if (c == jsu_pkg::CHAR_BACKSLASH) begin
         escape_pending = 1'b1;
      end else begin
         expect_beat(c, jsu_pkg::STATUS_DATA, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      beat_type want;
      if (reset) begin
         clear_escape();
         expected_beats.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected beat: byte %02h status %0d last %0b",
                                         rsp_out_byte, rsp_status, rsp_last));
            end else begin
               want = expected_beats.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_out_byte, want.out_byte));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
               end
            end
         end
         if (req_push && !req_full) begin
            decode_byte(req_in_byte);
         end
      end
      beats_outstanding = expected_beats.size();
   end

endmodule

// ===== sim/json_string_unescape_test.sv =====
`timescale 1ns / 1ps

module json_string_unescape_test;

   localparam int ITEM_COUNT = 310;
   localparam int QUIET_TAIL = 60;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_pop = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic       rsp_last;

   int failures;
   int beats_outstanding;
   int bytes_sent = 0;
   int feed_gap_odds = 0;
   int drain_gap_odds = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   json_string_unescape uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_in_byte(req_in_byte),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_out_byte(rsp_out_byte),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   json_string_unescape_checker decode_check (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_in_byte(req_in_byte),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_out_byte(rsp_out_byte),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last),
      .failures(failures),
      .beats_outstanding(beats_outstanding)
   );

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // result side stalls in random bursts
   initial begin
      @(negedge clock);
      forever begin
         if (drain_gap_odds != 0 && $urandom_range(0, 7) < drain_gap_odds) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(negedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (feed_gap_odds != 0 && $urandom_range(0, 7) < feed_gap_odds) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return 8'h30 + v;
      end else if ($urandom_range(0, 1) == 1) begin
         return 8'h61 + v - 8'd10;
      end else begin
         return 8'h41 + v - 8'd10;
      end
   endfunction

   task automatic send_unicode(input logic [15:0] v);
      send_byte(jsu_pkg::CHAR_BACKSLASH);
      send_byte(jsu_pkg::CHAR_U);
      send_byte(hex_char(v[15:12]));
      send_byte(hex_char(v[11:8]));
      send_byte(hex_char(v[7:4]));
      send_byte(hex_char(v[3:0]));
   endtask

   function automatic logic [7:0] random_plain();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(4, 254));
      end while (c == jsu_pkg::CHAR_QUOTE || c == jsu_pkg::CHAR_BACKSLASH);
      return c;
   endfunction

   function automatic logic [7:0] escape_letter();
      case ($urandom_range(0, 7))
         0: return jsu_pkg::CHAR_QUOTE;
         1: return jsu_pkg::CHAR_BACKSLASH;
         2: return jsu_pkg::CHAR_SLASH;
         3: return jsu_pkg::CHAR_B;
         4: return jsu_pkg::CHAR_F;
         5: return jsu_pkg::CHAR_N;
         6: return jsu_pkg::CHAR_R;
         default: return jsu_pkg::CHAR_T;
      endcase
   endfunction

   function automatic logic [15:0] random_code_unit();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 16'h007f));
         1: return 16'($urandom_range(16'h0080, 16'h07ff));
         2: return 16'($urandom_range(16'h0800, 16'hffff));
         default: begin
            case ($urandom_range(0, 7))
               0: return 16'h0000;
               1: return 16'h007f;
               2: return 16'h0080;
               3: return 16'h07ff;
               4: return 16'h0800;
               5: return 16'hd800;
               6: return 16'hdfff;
               default: return 16'hffff;
            endcase
         end
      endcase
   endfunction

   task automatic send_token();
      int k;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7: send_byte(random_plain());
         8, 9, 10: begin
            send_byte(jsu_pkg::CHAR_BACKSLASH);
            send_byte(escape_letter());
         end
         11, 12, 13, 14: send_unicode(random_code_unit());
         15: send_byte(8'($urandom_range(0, 255)));
         16: begin
            if ($urandom_range(0, 4) == 0) begin
               send_byte(jsu_pkg::CHAR_EOF);
            end else begin
               send_byte(8'($urandom_range(0, 3)));
            end
         end
         17: begin
            send_byte(jsu_pkg::CHAR_BACKSLASH);
            send_byte(8'($urandom_range(0, 255)));
         end
         18: begin
            send_byte(jsu_pkg::CHAR_BACKSLASH);
            send_byte(jsu_pkg::CHAR_U);
            k = $urandom_range(0, 3);
            repeat (k) send_byte(hex_char(4'($urandom_range(0, 15))));
            send_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            send_byte(jsu_pkg::CHAR_BACKSLASH);
            send_byte(8'($urandom_range(0, 3)));
         end
      endcase
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      feed_gap_odds = 2;
      drain_gap_odds = 2;

      send_byte(8'h04);
      send_byte(8'hfe);
      send_byte(jsu_pkg::CHAR_BACKSLASH);
      send_byte(jsu_pkg::CHAR_N);
      send_byte(8'h00);
      send_byte(jsu_pkg::CHAR_EOF);
      // control byte right after a backslash
      send_byte(jsu_pkg::CHAR_BACKSLASH);
      send_byte(8'h03);
      // unknown escape letter
      send_byte(jsu_pkg::CHAR_BACKSLASH);
      send_byte(8'h71);
      // quote in the middle of a unicode escape
      send_byte(jsu_pkg::CHAR_BACKSLASH);
      send_byte(jsu_pkg::CHAR_U);
      send_byte(jsu_pkg::CHAR_QUOTE);
      // lone surrogate, then a two byte sequence
      send_unicode(16'hd83d);
      send_unicode(16'h07ff);
      send_byte(jsu_pkg::CHAR_QUOTE);

      while (bytes_sent < ITEM_COUNT) begin
         if (bytes_sent >= ITEM_COUNT - QUIET_TAIL) begin
            feed_gap_odds = 0;
            drain_gap_odds = 0;
         end else begin
            feed_gap_odds = $urandom_range(0, 3);
            drain_gap_odds = $urandom_range(0, 3);
         end
         repeat ($urandom_range(1, 8)) send_token();
         if ($urandom_range(0, 3) != 0) begin
            send_byte(jsu_pkg::CHAR_QUOTE);
         end
      end
      req_push <= 1'b0;

      while (beats_outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
